// ===== sv/dfpma_pkg.sv =====
// ----------------------------------------------------------------------------
// dfpma_pkg
// shared types and constants of the dust frame parser with moving average
// ----------------------------------------------------------------------------
package dfpma_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_HEAD = 2'd0;
	localparam logic [1:0] REG_TAIL = 2'd1;
	localparam logic [1:0] REG_GAIN = 2'd2;

	localparam int CFG_AW = 2;
	localparam int CFG_DW = 16;

	// register reset values
	localparam logic [7:0]  HEAD_RST = 8'hAA;
	localparam logic [7:0]  TAIL_RST = 8'hFF;
	localparam logic [15:0] GAIN_RST = 16'd1000;

	// window depth default
	localparam int WINDOW_DEF = 100;

	// byte position of the tail within a frame
	localparam logic [2:0] POS_TAIL = 3'd6;

	// 5 * gain fits in 19 bits
	localparam int GAIN5_W = 19;

	// frame result codes
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_CSUM = 2'd1,
		ST_DROP = 2'd2
	} status_t;

	localparam int SAMPLE_W = 16;

endpackage

// ===== sv/dfpma_ram.sv =====
// ----------------------------------------------------------------------------
// dfpma_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module dfpma_ram #(
	parameter int WIDTH = dfpma_pkg::SAMPLE_W,
	parameter int DEPTH = dfpma_pkg::WINDOW_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/dust_frame_parser_moving_average_top.sv =====
// ----------------------------------------------------------------------------
// dust_frame_parser_moving_average_top
// finds 7-byte sensor frames in a byte stream, checks them and keeps a
// moving average of the frame samples, scaled into a concentration
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                                   request when
//  s_axis    in   tdata[7:0] rx_byte                        tvalid & tready
//  m_axis    out  tdata[15:0] concentration,                tvalid & tready
//                 tdata[31:16] raw_sample,
//                 tuser[1:0] frame_status, tuser[2] average_ready
//  cfg       in   addr 0 head, 1 tail, 2 gain; wdata        we
//
//  one byte is taken every cycle while no tail byte waits; only a tail
//  byte produces a result, registered through stages s1 to s4 and m_axis
//  the window sits in one ram: read at the tail byte, sum updated and the
//  sample written back in the cycle after, then multiply, scale and saturate
//  only one frame is in flight: a tail byte waits while the previous result
//  is still in the pipe or not yet taken (seven bytes per frame keep this rare)
//  no clearing pass after reset: until the write slot first wraps, the
//  entry being replaced has never been written and counts as zero
//
module dust_frame_parser_moving_average_top #(
	parameter int WINDOW = dfpma_pkg::WINDOW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// byte stream in
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
	// frame results out
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [31:0]                   m_axis_tdata,  // [15:0] concentration, [31:16] raw_sample
	output logic [2:0]                    m_axis_tuser,  // [1:0] frame_status, [2] average_ready
	// configuration writes
	input  logic                          cfg_we,
	input  logic [dfpma_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [dfpma_pkg::CFG_DW-1:0]  cfg_wdata
);

	// window slot and sum widths
	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W  = $clog2(WINDOW * 65535 + 1);
	localparam int PROD_W = SUM_W + dfpma_pkg::GAIN5_W;
	// after the divide by 1024
	localparam int T_W    = PROD_W - 10;
	// divide by WINDOW through a reciprocal: exact for dividends below 2^QN
	localparam int LG     = $clog2(WINDOW);
	localparam int QN     = 16 + LG;
	localparam int REC_W  = 2 * QN + 1;
	localparam longint unsigned RECIP_L =
		((64'd1 << (QN + LG)) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
	localparam logic [QN:0] RECIP = RECIP_L[QN:0];
	// scaled value saturates at 65535 once num/1024 reaches 65536*WINDOW
	localparam longint unsigned SAT_L = 64'd65536 * 64'(WINDOW);
	localparam logic [T_W-1:0] SAT_LIM = SAT_L[T_W-1:0];
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

	// configuration
	logic [7:0]                      head_q;
	logic [7:0]                      tail_q;
	logic [dfpma_pkg::GAIN5_W-1:0]   gain5_q;

	// frame assembly
	logic [2:0]  pos_q;
	logic [7:0]  b1_q, b2_q, b5_q, chk_q;

	// window state
	logic [SLOT_W-1:0] slot_q;
	logic              ready_q;
	logic [SUM_W-1:0]  sum_q;
	logic [15:0]       held_q;

	// pipeline
	logic                   v_s1, v_s2, v_s3, v_s4;
	dfpma_pkg::status_t     st_s1, st_s2, st_s3, st_s4;
	logic [15:0]            smp_s1, smp_s2, smp_s3, smp_s4;
	logic                   rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic                   wrap_s1;
	logic [SLOT_W-1:0]      slot_s1;
	logic [PROD_W-1:0]      prod_s3;
	logic                   sat_s4;
	logic [REC_W-1:0]       rec_s4;

	logic                   in_req;
	logic                   busy;
	logic                   at_tail;
	logic [7:0]             rx;
	dfpma_pkg::status_t     st_new;
	logic                   win_upd;
	logic [SLOT_W-1:0]      slot_nxt;
	logic                   ready_nxt;
	logic [15:0]            ram_rdata;
	logic [15:0]            old_smp;
	logic                   wr_s1;
	logic [T_W-1:0]         t_s3;
	logic [15:0]            scaled;
	logic                   upd_s4;
	logic [15:0]            conc;

	assign rx      = s_axis_tdata;
	assign at_tail = (pos_q == dfpma_pkg::POS_TAIL);
	// a tail byte enters only into an empty pipe and output register
	assign busy    = v_s1 | v_s2 | v_s3 | v_s4 | m_axis_tvalid;
	assign s_axis_tready = !(at_tail && busy);
	assign in_req  = s_axis_tvalid && s_axis_tready;

	// frame verdict at the tail byte
	always_comb begin
		if (rx != tail_q) begin
			st_new = dfpma_pkg::ST_DROP;
		end else if (chk_q == b5_q) begin
			st_new = dfpma_pkg::ST_OK;
		end else begin
			st_new = dfpma_pkg::ST_CSUM;
		end
	end

	assign win_upd   = in_req && at_tail && (st_new == dfpma_pkg::ST_OK);
	assign slot_nxt  = (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
	assign ready_nxt = ready_q | (slot_nxt == '0);

	// window memory: read the slot being replaced, write the new sample next cycle
	assign wr_s1 = v_s1 && (st_s1 == dfpma_pkg::ST_OK);

	dfpma_ram #(
		.WIDTH(dfpma_pkg::SAMPLE_W),
		.DEPTH(WINDOW)
	) u_ram (
		.clk   (clk),
		.we    (wr_s1),
		.waddr (slot_s1),
		.wdata (smp_s1),
		.re    (win_upd),
		.raddr (slot_q),
		.rdata (ram_rdata)
	);

	// an entry not yet written since reset reads as zero
	assign old_smp = wrap_s1 ? ram_rdata : '0;

	// scaling datapath
	assign t_s3   = prod_s3[PROD_W-1:10];
	assign scaled = sat_s4 ? 16'hFFFF : rec_s4[QN+LG +: 16];
	assign upd_s4 = v_s4 && (st_s4 == dfpma_pkg::ST_OK) && rdy_s4;
	assign conc   = upd_s4 ? scaled : held_q;

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q        <= dfpma_pkg::HEAD_RST;
			tail_q        <= dfpma_pkg::TAIL_RST;
			gain5_q       <= dfpma_pkg::GAIN5_W'(dfpma_pkg::GAIN_RST) * dfpma_pkg::GAIN5_W'(5);
			pos_q         <= '0;
			slot_q        <= '0;
			ready_q       <= 1'b0;
			sum_q         <= '0;
			held_q        <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			v_s4          <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					dfpma_pkg::REG_HEAD: head_q <= cfg_wdata[7:0];
					dfpma_pkg::REG_TAIL: tail_q <= cfg_wdata[7:0];
					// keep 5 * gain ready for the multiplier
					dfpma_pkg::REG_GAIN: gain5_q <= dfpma_pkg::GAIN5_W'(cfg_wdata)
						+ (dfpma_pkg::GAIN5_W'(cfg_wdata) << 2);
					default: ;
				endcase
			end

			if (in_req) begin
				if (pos_q == '0) begin
					if (rx == head_q) begin
						pos_q <= 3'd1;
					end
				end else if (at_tail) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 3'd1;
				end
			end

			if (win_upd) begin
				slot_q  <= slot_nxt;
				ready_q <= ready_nxt;
			end

			if (wr_s1) begin
				sum_q <= SUM_W'({1'b0, sum_q} + (SUM_W + 1)'(smp_s1) - (SUM_W + 1)'(old_smp));
			end

			if (upd_s4) begin
				held_q <= scaled;
			end

			v_s1 <= in_req && at_tail;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;

			if (v_s4) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_req) begin
			case (pos_q)
				3'd1: begin
					b1_q  <= rx;
					chk_q <= rx;
				end
				3'd2: begin
					b2_q  <= rx;
					chk_q <= chk_q + rx;
				end
				3'd3, 3'd4: chk_q <= chk_q + rx;
				3'd5: b5_q <= rx;
				default: ;
			endcase
		end

		// stage 1: verdict, slot and readiness after this frame
		st_s1   <= st_new;
		smp_s1  <= {b1_q, b2_q};
		wrap_s1 <= ready_q;
		slot_s1 <= slot_q;
		rdy_s1  <= (st_new == dfpma_pkg::ST_OK) ? ready_nxt : ready_q;

		// stage 2: running sum updated
		st_s2  <= st_s1;
		smp_s2 <= smp_s1;
		rdy_s2 <= rdy_s1;

		// stage 3: sum * 5 * gain
		st_s3   <= st_s2;
		smp_s3  <= smp_s2;
		rdy_s3  <= rdy_s2;
		prod_s3 <= PROD_W'(sum_q) * PROD_W'(gain5_q);

		// stage 4: saturation test and reciprocal multiply
		st_s4  <= st_s3;
		smp_s4 <= smp_s3;
		rdy_s4 <= rdy_s3;
		sat_s4 <= (t_s3 >= SAT_LIM);
		rec_s4 <= REC_W'(t_s3[QN-1:0]) * REC_W'(RECIP);

		if (v_s4) begin
			m_axis_tdata <= {smp_s4, conc};
			m_axis_tuser <= {rdy_s4, st_s4};
		end
	end

endmodule

// ===== sv/dfpma_chk.sv =====
// ----------------------------------------------------------------------------
// dfpma_chk
// port-level checks of the dust frame parser, bound to the top level
// ----------------------------------------------------------------------------
module dfpma_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser,
	input logic        cfg_we,
	input logic [1:0]  cfg_addr,
	input logic [15:0] cfg_wdata
);

	logic rdy_seen_q;

	// average_ready seen on an earlier result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy_seen_q <= 1'b0;
		end else if (m_axis_tvalid && m_axis_tready && m_axis_tuser[2]) begin
			rdy_seen_q <= 1'b1;
		end
	end

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// no status code beyond dropped
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[1:0] != 2'd3))
		else $error("bad frame status");

	// once the window has filled it stays filled
	a_ready_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && rdy_seen_q |-> m_axis_tuser[2])
		else $error("average ready fell");

	// no concentration before the window has filled
	a_conc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[2] |-> (m_axis_tdata[15:0] == 16'd0))
		else $error("concentration before ready");

endmodule

bind dust_frame_parser_moving_average_top dfpma_chk u_dfpma_chk (.*);
